// File: rtl/core/gdm_pkg.sv
// Shared types, codes and constants of the grid distance map unit.
// Used by the top level; depends on nothing.
`default_nettype none

package gdm_pkg;

	// Widths fixed by the result and configuration fields.
	localparam int unsigned COST_W = 21;
	localparam int unsigned DIM_W  = 7;

	// Cost values in Q8 grid units.
	localparam logic [COST_W-1:0] UNREACHED     = 21'h1FFFFF;
	localparam logic [COST_W-1:0] COST_CAP      = 21'h1FFFFE;
	localparam logic [COST_W-1:0] STEP_STRAIGHT = 21'd256;
	localparam logic [COST_W-1:0] STEP_DIAGONAL = 21'd362;

	// Default geometry and frontier size.
	localparam int unsigned DEF_MAX_COLUMNS    = 64;
	localparam int unsigned DEF_MAX_ROWS       = 64;
	localparam int unsigned DEF_FRONTIER_DEPTH = 8192;
	localparam logic [DIM_W-1:0] DIM_RESET     = 7'd64;

	// Command codes carried in the request tuser.
	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_RUN   = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_QWAIT, S_RESULT, S_CLEAR, S_SEED, S_PUSH, S_UP,
		S_UPCMP, S_NEXT, S_POP, S_POPR, S_POPL, S_DN, S_DNL, S_DNR, S_DNC,
		S_CHK, S_CHKW, S_NB, S_NBW
	} state_t;

	// Column offset plus one of neighbor slot nb (rows above, at, below).
	function automatic logic [1:0] nb_dxp(input logic [3:0] nb);
		logic [1:0] r;
		unique case (nb)
			4'd0, 4'd3, 4'd6: r = 2'd0;
			4'd1, 4'd4, 4'd7: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

	// Row offset plus one of neighbor slot nb.
	function automatic logic [1:0] nb_dyp(input logic [3:0] nb);
		logic [1:0] r;
		unique case (nb)
			4'd0, 4'd1, 4'd2: r = 2'd0;
			4'd3, 4'd4, 4'd5: r = 2'd1;
			default:          r = 2'd2;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/grid_dijkstra_distance_map_unit.sv
// Grid distance map: 8-connected Dijkstra search over a blocked-cell map.
// Load writes the blocked bit, a query reads the cost RAM, and a run clears all 2^AW
// cells, then pops each expanded cell from the heap frontier and pushes each relaxed
// neighbor; one frontier RAM port sets the pace.
// Throughput: one request at a time; s_tready is low while a request works.
// Reset: all control clears, then a pass over all 2^AW cells frees and unreaches them.
// Depends on gdm_pkg and gdm_ram.
`default_nettype none

module grid_dijkstra_distance_map_unit #(
	parameter int unsigned MAX_COLUMNS    = gdm_pkg::DEF_MAX_COLUMNS,
	parameter int unsigned MAX_ROWS       = gdm_pkg::DEF_MAX_ROWS,
	parameter int unsigned FRONTIER_DEPTH = gdm_pkg::DEF_FRONTIER_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // cell_x[5:0], cell_y[11:6], blocked[12], zero
	input  wire logic [1:0]  s_tuser,   // cmd[1:0]
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // path_cost[20:0], reached[21], zero
	output logic      [1:0]  m_tuser,   // search_done[0], queue_overflow[1]
	// Configuration writes.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [6:0]  cfg_data
);

	localparam int unsigned CW = $clog2(MAX_COLUMNS);
	localparam int unsigned RW = $clog2(MAX_ROWS);
	localparam int unsigned AW = CW + RW;
	localparam int unsigned CELLS = 2 ** AW;
	localparam int unsigned CSTW = gdm_pkg::COST_W;
	localparam int unsigned EW = CSTW + AW;
	localparam int unsigned HW = $clog2(FRONTIER_DEPTH);
	localparam int unsigned LW = HW + 1;
	localparam logic [8:0] MAXC9 = 9'(MAX_COLUMNS);
	localparam logic [8:0] MAXR9 = 9'(MAX_ROWS);
	localparam logic [LW-1:0] FULL = LW'(FRONTIER_DEPTH);

	gdm_pkg::state_t state_q, state_d;

	// Registers.
	logic [gdm_pkg::DIM_W-1:0] width_q, height_q;
	logic [AW-1:0]   cnt_q;
	logic [5:0]      tx_q, ty_q;
	logic            qin_q;
	logic [LW-1:0]   len_q;
	logic            ovf_q;
	logic [HW-1:0]   i_q, ci_q;
	logic [EW-1:0]   item_q, child_q;
	logic [CSTW-1:0] cur_cost_q;
	logic [AW-1:0]   cur_cell_q;
	logic [3:0]      nb_q;
	logic [CSTW-1:0] res_cost_q;
	logic            res_done_q, res_ovf_q;
	logic            m_tvalid_q;
	logic [CSTW-1:0] m_cost_q;
	logic            m_reached_q, m_done_q, m_ovf_q;

	// RAM ports.
	logic            cost_we, obs_we, obs_wdata, obs_rdata, heap_we;
	logic [AW-1:0]   cost_waddr, cost_raddr, obs_waddr, obs_raddr;
	logic [CSTW-1:0] cost_wdata, cost_rdata;
	logic [HW-1:0]   heap_waddr, heap_raddr;
	logic [EW-1:0]   heap_wdata, heap_rdata;

	// Request decode.
	logic [5:0]    in_x, in_y;
	logic          in_inside, accept;
	logic [AW-1:0] in_cell, t_cell;
	assign in_x      = s_tdata[5:0];
	assign in_y      = s_tdata[11:6];
	assign in_inside = (9'(in_x) < MAXC9) && (9'(in_y) < MAXR9);
	assign in_cell   = {RW'(in_y), CW'(in_x)};
	assign t_cell    = {RW'(ty_q), CW'(tx_q)};
	assign s_tready  = (state_q == gdm_pkg::S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Grid size in use, clamped to the storage.
	logic [8:0] w_eff, h_eff;
	always_comb begin
		w_eff = (width_q == '0) ? 9'd1 : ((9'(width_q) > MAXC9) ? MAXC9 : 9'(width_q));
		h_eff = (height_q == '0) ? 9'd1 : ((9'(height_q) > MAXR9) ? MAXR9 : 9'(height_q));
	end
	logic t_in_grid;
	assign t_in_grid = (9'(tx_q) < w_eff) && (9'(ty_q) < h_eff);

	// Neighbor address and relaxed cost for slot nb_q.
	logic [9:0]      nxp, nyp;
	logic            nb_ok, diag, take;
	logic [AW-1:0]   n_cell;
	logic [CSTW:0]   sum;
	logic [CSTW-1:0] nc;
	always_comb begin
		nxp    = 10'(cur_cell_q[CW-1:0]) + 10'(gdm_pkg::nb_dxp(nb_q));
		nyp    = 10'(cur_cell_q[AW-1:CW]) + 10'(gdm_pkg::nb_dyp(nb_q));
		nb_ok  = (nxp != '0) && (nxp <= 10'(w_eff)) && (nyp != '0) && (nyp <= 10'(h_eff));
		n_cell = {RW'(nyp - 10'd1), CW'(nxp - 10'd1)};
		diag   = (gdm_pkg::nb_dxp(nb_q) != 2'd1) && (gdm_pkg::nb_dyp(nb_q) != 2'd1);
		sum    = (CSTW+1)'(cur_cost_q)
			+ (CSTW+1)'(diag ? gdm_pkg::STEP_DIAGONAL : gdm_pkg::STEP_STRAIGHT);
		nc     = (sum > (CSTW+1)'(gdm_pkg::COST_CAP)) ? gdm_pkg::COST_CAP : sum[CSTW-1:0];
		take   = !obs_rdata && (nc < cost_rdata);
	end

	// Heap index arithmetic.
	logic [HW-1:0] parent;
	logic [HW+1:0] lchild, rchild;
	assign parent = HW'((i_q - HW'(1)) >> 1);
	assign lchild = {1'b0, i_q, 1'b1};
	assign rchild = lchild + (HW+2)'(1);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gdm_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and RAM controls.
	always_comb begin
		state_d    = state_q;
		cost_we    = 1'b0;
		cost_waddr = cnt_q;
		cost_wdata = gdm_pkg::UNREACHED;
		cost_raddr = n_cell;
		obs_we     = 1'b0;
		obs_waddr  = cnt_q;
		obs_wdata  = 1'b0;
		obs_raddr  = n_cell;
		heap_we    = 1'b0;
		heap_waddr = i_q;
		heap_wdata = item_q;
		heap_raddr = '0;
		unique case (state_q)
			gdm_pkg::S_INIT: begin
				cost_we = 1'b1;
				obs_we  = 1'b1;
				if (cnt_q == '1) state_d = gdm_pkg::S_IDLE;
			end
			gdm_pkg::S_IDLE: begin
				if (s_tvalid) begin
					unique case (gdm_pkg::cmd_t'(s_tuser))
						gdm_pkg::CMD_LOAD: begin
							obs_we    = in_inside;
							obs_waddr = in_cell;
							obs_wdata = s_tdata[12];
						end
						gdm_pkg::CMD_RUN: state_d = gdm_pkg::S_CLEAR;
						gdm_pkg::CMD_QUERY: begin
							cost_raddr = in_cell;
							state_d    = gdm_pkg::S_QWAIT;
						end
						default: state_d = gdm_pkg::S_IDLE;
					endcase
				end
			end
			gdm_pkg::S_QWAIT: state_d = gdm_pkg::S_RESULT;
			gdm_pkg::S_RESULT: begin
				if (!m_tvalid_q || m_tready) state_d = gdm_pkg::S_IDLE;
			end
			gdm_pkg::S_CLEAR: begin
				cost_we = 1'b1;
				if (cnt_q == '1) begin
					state_d = t_in_grid ? gdm_pkg::S_SEED : gdm_pkg::S_RESULT;
				end
			end
			gdm_pkg::S_SEED: begin
				cost_we    = 1'b1;
				cost_waddr = t_cell;
				cost_wdata = '0;
				state_d    = gdm_pkg::S_PUSH;
			end
			gdm_pkg::S_PUSH: begin
				state_d = (len_q == FULL) ? gdm_pkg::S_NEXT : gdm_pkg::S_UP;
			end
			gdm_pkg::S_UP: begin
				if (i_q == '0) begin
					heap_we = 1'b1;
					state_d = gdm_pkg::S_NEXT;
				end else begin
					heap_raddr = parent;
					state_d    = gdm_pkg::S_UPCMP;
				end
			end
			gdm_pkg::S_UPCMP: begin
				heap_we = 1'b1;
				if (item_q < heap_rdata) begin
					heap_wdata = heap_rdata;
					state_d    = gdm_pkg::S_UP;
				end else begin
					state_d = gdm_pkg::S_NEXT;
				end
			end
			gdm_pkg::S_NEXT: begin
				state_d = (nb_q == 4'd8) ? gdm_pkg::S_POP : gdm_pkg::S_NB;
			end
			gdm_pkg::S_POP: begin
				state_d = (len_q == '0) ? gdm_pkg::S_RESULT : gdm_pkg::S_POPR;
			end
			gdm_pkg::S_POPR: begin
				heap_raddr = HW'(len_q - LW'(1));
				state_d    = gdm_pkg::S_POPL;
			end
			gdm_pkg::S_POPL: begin
				state_d = (len_q == '0) ? gdm_pkg::S_CHK : gdm_pkg::S_DN;
			end
			gdm_pkg::S_DN: begin
				if (lchild >= (HW+2)'(len_q)) begin
					heap_we = 1'b1;
					state_d = gdm_pkg::S_CHK;
				end else begin
					heap_raddr = HW'(lchild);
					state_d    = gdm_pkg::S_DNL;
				end
			end
			gdm_pkg::S_DNL: begin
				if (rchild < (HW+2)'(len_q)) begin
					heap_raddr = HW'(rchild);
					state_d    = gdm_pkg::S_DNR;
				end else begin
					state_d = gdm_pkg::S_DNC;
				end
			end
			gdm_pkg::S_DNR: state_d = gdm_pkg::S_DNC;
			gdm_pkg::S_DNC: begin
				heap_we = 1'b1;
				if (child_q < item_q) begin
					heap_wdata = child_q;
					state_d    = gdm_pkg::S_DN;
				end else begin
					state_d = gdm_pkg::S_CHK;
				end
			end
			gdm_pkg::S_CHK: begin
				cost_raddr = cur_cell_q;
				state_d    = gdm_pkg::S_CHKW;
			end
			gdm_pkg::S_CHKW: begin
				state_d = (cur_cost_q != cost_rdata) ? gdm_pkg::S_POP : gdm_pkg::S_NB;
			end
			gdm_pkg::S_NB: begin
				state_d = nb_ok ? gdm_pkg::S_NBW : gdm_pkg::S_NEXT;
			end
			gdm_pkg::S_NBW: begin
				if (take) begin
					cost_we    = 1'b1;
					cost_waddr = n_cell;
					cost_wdata = nc;
					state_d    = gdm_pkg::S_PUSH;
				end else begin
					state_d = gdm_pkg::S_NEXT;
				end
			end
			default: state_d = gdm_pkg::S_IDLE;
		endcase
	end

	// Control registers of the search.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			len_q <= '0;
			ovf_q <= 1'b0;
			nb_q  <= '0;
		end else begin
			unique case (state_q)
				gdm_pkg::S_INIT: cnt_q <= cnt_q + AW'(1);
				gdm_pkg::S_CLEAR: begin
					cnt_q <= cnt_q + AW'(1);
					len_q <= '0;
					ovf_q <= 1'b0;
				end
				gdm_pkg::S_SEED: nb_q <= 4'd8;
				gdm_pkg::S_PUSH: begin
					if (len_q == FULL) ovf_q <= 1'b1;
					else len_q <= len_q + LW'(1);
				end
				gdm_pkg::S_NEXT: nb_q <= (nb_q == 4'd3) ? 4'd5 : nb_q + 4'd1;
				gdm_pkg::S_POPR: len_q <= len_q - LW'(1);
				gdm_pkg::S_CHKW: nb_q <= (nb_q == 4'd3) ? 4'd5 : 4'd0;
				default: nb_q <= nb_q;
			endcase
		end
	end

	// Datapath registers of the search.
	always_ff @(posedge clk) begin
		unique case (state_q)
			gdm_pkg::S_IDLE: begin
				tx_q  <= in_x;
				ty_q  <= in_y;
				qin_q <= in_inside;
			end
			gdm_pkg::S_QWAIT: begin
				res_cost_q <= qin_q ? cost_rdata : gdm_pkg::UNREACHED;
				res_done_q <= 1'b0;
				res_ovf_q  <= 1'b0;
			end
			gdm_pkg::S_CLEAR: begin
				res_cost_q <= '0;
				res_done_q <= 1'b1;
				res_ovf_q  <= 1'b0;
			end
			gdm_pkg::S_SEED: item_q <= {CSTW'(0), t_cell};
			gdm_pkg::S_PUSH: i_q <= HW'(len_q);
			gdm_pkg::S_UPCMP: begin
				if (item_q < heap_rdata) i_q <= parent;
			end
			gdm_pkg::S_POP: begin
				res_cost_q <= '0;
				res_done_q <= 1'b1;
				res_ovf_q  <= ovf_q;
			end
			gdm_pkg::S_POPR: begin
				cur_cost_q <= heap_rdata[EW-1:AW];
				cur_cell_q <= heap_rdata[AW-1:0];
			end
			gdm_pkg::S_POPL: begin
				item_q <= heap_rdata;
				i_q    <= '0;
			end
			gdm_pkg::S_DNL: begin
				child_q <= heap_rdata;
				ci_q    <= HW'(lchild);
			end
			gdm_pkg::S_DNR: begin
				if (heap_rdata < child_q) begin
					child_q <= heap_rdata;
					ci_q    <= HW'(rchild);
				end
			end
			gdm_pkg::S_DNC: begin
				if (child_q < item_q) i_q <= ci_q;
			end
			gdm_pkg::S_NBW: begin
				if (take) item_q <= {nc, n_cell};
			end
			default: i_q <= i_q;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= gdm_pkg::DIM_RESET;
			height_q <= gdm_pkg::DIM_RESET;
		end else if (cfg_valid) begin
			unique case (gdm_pkg::reg_idx_t'(cfg_index))
				gdm_pkg::REG_WIDTH:  width_q  <= cfg_data;
				gdm_pkg::REG_HEIGHT: height_q <= cfg_data;
				default:             width_q  <= width_q;
			endcase
		end
	end

	// Output register; a waiting result does not block new requests.
	logic out_load;
	assign out_load = (state_q == gdm_pkg::S_RESULT) && (!m_tvalid_q || m_tready);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end
	// A run result always reports reached as zero; only a query carries a cost.
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_cost_q    <= res_cost_q;
			m_reached_q <= (res_cost_q != gdm_pkg::UNREACHED) && !res_done_q;
			m_done_q    <= res_done_q;
			m_ovf_q     <= res_ovf_q;
		end
	end
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, m_reached_q, m_cost_q};
	assign m_tuser  = {m_ovf_q, m_done_q};

	// Memories.
	gdm_ram #(.WIDTH(CSTW), .DEPTH(CELLS)) u_cost_ram (
		.clk(clk), .we(cost_we), .waddr(cost_waddr), .wdata(cost_wdata),
		.raddr(cost_raddr), .rdata(cost_rdata)
	);
	gdm_ram #(.WIDTH(1), .DEPTH(CELLS)) u_obs_ram (
		.clk(clk), .we(obs_we), .waddr(obs_waddr), .wdata(obs_wdata),
		.raddr(obs_raddr), .rdata(obs_rdata)
	);
	gdm_ram #(.WIDTH(EW), .DEPTH(FRONTIER_DEPTH)) u_heap_ram (
		.clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
		.raddr(heap_raddr), .rdata(heap_rdata)
	);

`ifndef SYNTH
	// The frontier never holds more entries than it has room for.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= FULL) else $error("frontier length beyond depth");

	// A push into a full frontier raises the overflow flag.
	a_ovf_set: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gdm_pkg::S_PUSH && len_q == FULL) |=> ovf_q)
		else $error("overflow not flagged");

	// A pop only starts on a non-empty frontier.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gdm_pkg::S_POPR) |-> (len_q != '0))
		else $error("pop from empty frontier");

	// An accepted query request moves to the read wait state.
	a_query_path: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == gdm_pkg::CMD_QUERY) |=> (state_q == gdm_pkg::S_QWAIT))
		else $error("query not started");
`endif

endmodule

`default_nettype wire

// File: rtl/core/gdm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none

module gdm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
